// ===== rtl/pfcp_tt_pkg.sv =====
`default_nettype none
package pfcp_tt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int MAX_OUT = 16;
    localparam logic [23:0] ID_WRAP = 24'h800000;

    typedef enum logic [2:0] {
        REQ_CREATE   = 3'd0,
        REQ_TRANSMIT = 3'd1,
        REQ_RECEIVE  = 3'd2,
        REQ_COMMIT   = 3'd3,
        REQ_DCOMMIT  = 3'd4,
        REQ_TICK     = 3'd5,
        REQ_DELETE   = 3'd6
    } t_req;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RETRY = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_REQ  = 2'd1;
    localparam logic [1:0] KIND_RSP  = 2'd2;

    localparam logic [7:0] MSG_VERSION_NOT_SUPPORTED = 8'd11;

    typedef struct packed {
        logic            remote;
        logic [23:0]     id;
        logic [1:0]      step;
        logic [2:0][7:0] msg;
        logic [2:0]      mask;
        logic [3:0]      rleft;
        logic [3:0]      hleft;
        logic [15:0]     rtimer;
        logic [15:0]     htimer;
        logic [15:0]     ctimer;
    } t_rec;

    typedef struct packed {
        logic [3:0]  rretries;
        logic [15:0] rticks;
        logic [3:0]  hretries;
        logic [15:0] hticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] st;
        logic       send;
        logic [1:0] sstep;
        logic       gave;
        logic       rem;
    } t_res;

    typedef struct packed {
        t_rec rec;
        logic keep;
        t_res res;
    } t_cres;

    function automatic logic [1:0] kind_of(input logic [7:0] t);
        logic [1:0] k;
        case (t) inside
            8'd1, 8'd5, 8'd7, 8'd9, 8'd50, 8'd52, 8'd54, 8'd56: k = KIND_REQ;
            8'd2, 8'd6, 8'd8, 8'd10, 8'd11, 8'd51, 8'd53, 8'd55, 8'd57: k = KIND_RSP;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] max1(input logic [15:0] p);
        return (p == 16'd0) ? 16'd1 : p;
    endfunction

    function automatic t_cres commit_fn(input t_rec r, input logic [15:0] rticks);
        t_cres      c;
        logic [1:0] k;
        logic [1:0] sm1;
        logic       fail;
        logic       fin;
        c = '0;
        c.rec = r;
        c.keep = 1'b1;
        fail = 1'b0;
        fin = 1'b0;
        sm1 = r.step - 2'd1;
        k = kind_of(r.msg[sm1]);
        if (r.step == 2'd0) begin
            fail = 1'b1;
        end else if (!r.remote) begin
            if (k == KIND_REQ) begin
                if (r.step != 2'd1) fail = 1'b1;
                else c.rec.rtimer = max1(rticks);
            end else if (k == KIND_RSP) begin
                if (r.step == 2'd2) fin = 1'b1;
                else if (r.step != 2'd3) fail = 1'b1;
            end else begin
                fail = 1'b1;
            end
        end else begin
            if (k != KIND_RSP || (r.step != 2'd2 && r.step != 2'd3)) fail = 1'b1;
            else if (r.step == 2'd3) fin = 1'b1;
        end
        if (fail) begin
            c.rec = r;
            c.keep = 1'b0;
            c.res.rem = 1'b1;
            c.res.st = ST_ERR;
        end else if (fin) begin
            c.keep = 1'b0;
            c.res.rem = 1'b1;
        end else begin
            c.res.send = r.mask[sm1];
            c.res.sstep = sm1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pfcp_tt_mem.sv =====
`default_nettype none
module pfcp_tt_mem
    import pfcp_tt_pkg::*;
#(
    parameter int DEPTH = SLOTS_DEF,
    parameter int AW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_rec          i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_rec               o_rdata
);

    t_rec r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/pfcp_tt_update.sv =====
`default_nettype none
module pfcp_tt_update
    import pfcp_tt_pkg::*;
(
    input  wire logic [2:0]  i_op,
    input  wire t_rec        i_rec,
    input  wire t_cfg        i_cfg,
    input  wire logic [7:0]  i_msg_type,
    input  wire logic [15:0] i_delay,
    output t_rec             o_rec,
    output logic             o_keep,
    output logic             o_hit,
    output t_res             o_res
);

    t_rec       r;
    t_res       res;
    t_cres      c;
    logic       keep;
    logic       hit;
    logic       fail;
    logic       adv;
    logic       good;
    logic [1:0] k;
    logic [1:0] sm1;

    always_comb begin
        r = i_rec;
        res = '0;
        keep = 1'b1;
        hit = 1'b0;
        fail = 1'b0;
        adv = 1'b0;
        good = 1'b0;
        c = '0;
        k = kind_of(i_msg_type);
        sm1 = i_rec.step - 2'd1;
        unique case (i_op)
            REQ_CREATE: begin
            end
            REQ_TRANSMIT: begin
                if (!i_rec.remote) begin
                    good = (k == KIND_REQ && i_rec.step == 2'd0) ||
                           (k == KIND_RSP && i_rec.step == 2'd2);
                end else begin
                    good = (k == KIND_RSP && i_rec.step == 2'd1);
                end
                if (good) begin
                    r.msg[i_rec.step] = i_msg_type;
                    r.mask[i_rec.step] = 1'b1;
                    r.step = i_rec.step + 2'd1;
                end else begin
                    res.st = ST_ERR;
                end
            end
            REQ_RECEIVE: begin
                if (!i_rec.remote) begin
                    if (k != KIND_RSP || i_rec.step != 2'd1) begin
                        fail = 1'b1;
                    end else if (i_msg_type != MSG_VERSION_NOT_SUPPORTED &&
                                 {1'b0, i_rec.msg[0]} + 9'd1 != {1'b0, i_msg_type}) begin
                        res.st = ST_RETRY;
                    end else begin
                        adv = 1'b1;
                    end
                end else if (k == KIND_REQ) begin
                    if (i_rec.msg[0] == i_msg_type) begin
                        if (i_rec.step != 2'd1 && i_rec.step != 2'd2) begin
                            fail = 1'b1;
                        end else begin
                            if (i_rec.mask[1]) begin
                                r.htimer = max1(i_cfg.hticks);
                                res.send = 1'b1;
                                res.sstep = 2'd1;
                            end
                            res.st = ST_RETRY;
                        end
                    end else if (i_rec.step != 2'd0) begin
                        fail = 1'b1;
                    end else begin
                        r.htimer = max1(i_cfg.hticks);
                        adv = 1'b1;
                    end
                end else begin
                    if (i_rec.step != 2'd2) fail = 1'b1;
                    else adv = 1'b1;
                end
                if (adv) begin
                    if (i_rec.step == 2'd3) begin
                        fail = 1'b1;
                    end else begin
                        r.rtimer = 16'd0;
                        r.msg[i_rec.step] = i_msg_type;
                        r.step = i_rec.step + 2'd1;
                    end
                end
                if (fail) begin
                    r = i_rec;
                    res = '0;
                    res.st = ST_ERR;
                    res.rem = 1'b1;
                    keep = 1'b0;
                end
            end
            REQ_COMMIT: begin
                c = commit_fn(i_rec, i_cfg.rticks);
                r = c.rec;
                keep = c.keep;
                res = c.res;
            end
            REQ_DCOMMIT: begin
                r.ctimer = max1(i_delay);
            end
            REQ_TICK: begin
                if (i_rec.rtimer != 16'd0) begin
                    r.rtimer = i_rec.rtimer - 16'd1;
                    if (r.rtimer == 16'd0) begin
                        hit = 1'b1;
                        if (i_rec.rleft > 4'd1) begin
                            r.rleft = i_rec.rleft - 4'd1;
                            r.rtimer = max1(i_cfg.rticks);
                            if (i_rec.step != 2'd0) begin
                                res.send = i_rec.mask[sm1];
                                res.sstep = sm1;
                            end
                            res.st = ST_RETRY;
                        end else begin
                            res.gave = !i_rec.remote;
                            keep = 1'b0;
                            res.rem = 1'b1;
                        end
                    end
                end
                if (keep && r.htimer != 16'd0) begin
                    r.htimer = r.htimer - 16'd1;
                    if (r.htimer == 16'd0) begin
                        hit = 1'b1;
                        if (r.hleft > 4'd1) begin
                            r.hleft = r.hleft - 4'd1;
                            r.htimer = max1(i_cfg.hticks);
                        end else begin
                            keep = 1'b0;
                            res.rem = 1'b1;
                        end
                    end
                end
                if (keep && r.ctimer != 16'd0) begin
                    r.ctimer = r.ctimer - 16'd1;
                    if (r.ctimer == 16'd0) begin
                        hit = 1'b1;
                        c = commit_fn(r, i_cfg.rticks);
                        r = c.rec;
                        keep = c.keep;
                        res.rem = res.rem | c.res.rem;
                        if (c.res.send) begin
                            res.send = 1'b1;
                            res.sstep = c.res.sstep;
                        end
                        if (c.res.st > res.st) res.st = c.res.st;
                    end
                end
            end
            REQ_DELETE: begin
                keep = 1'b0;
                res.rem = 1'b1;
            end
            default: begin
                res.st = ST_ERR;
            end
        endcase
        if (!res.send) res.sstep = 2'd0;
        o_rec = r;
        o_keep = keep;
        o_hit = hit;
        o_res = res;
    end

endmodule
`default_nettype wire

// ===== rtl/pfcp_transaction_table.sv =====
`default_nettype none
// PFCP transaction table for one peer. Each input word carries an event kind in tuser
// (create, transmit, receive, commit, delayed commit, tick, delete) and yields result
// words on the master side, the final one of an event marked by tlast; a tick yields one
// word per slot whose timer expires, at most sixteen, and none if nothing expires. All
// per-slot state but the valid bits lives in one synchronous memory with a registered
// read, so an event on an existing slot passes through a wait state for the read before
// it executes, while receive and tick walk the valid slots in turn, each read through
// the same wait state, and the master side can hold off any event's result. Valid bits
// sit in flip-flops and are cleared by reset, so no clearing pass is needed.
module pfcp_transaction_table
    import pfcp_tt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [22:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // slot[3:0], msg_type[11:4], seq_number[35:12], delay_ticks[51:36]
    input  wire logic [55:0] i_s_axis_tdata,
    // req_type[2:0]
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // status[1:0], entry[5:2], trans_id[29:6], send_now[30], send_step[32:31],
    // gave_up[33], removed[34]
    output logic [39:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW = $clog2(SLOTS + 1);
    localparam logic [2:0] CFG_RRETRIES = 3'd0;
    localparam logic [2:0] CFG_RTICKS   = 3'd1;
    localparam logic [2:0] CFG_HRETRIES = 3'd2;
    localparam logic [2:0] CFG_HTICKS   = 3'd3;
    localparam logic [2:0] CFG_FIRST_ID = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_WAIT, S_EXEC, S_DIRECT, S_RS_A, S_RS_C, S_TK_A, S_TK_C, S_TK_END
    } t_state;

    t_state      r_state, r_ret;
    t_cfg        r_cfg;
    logic [23:0] r_next_id;
    logic [SLOTS-1:0] r_valid;
    logic [2:0]  r_op;
    logic [7:0]  r_msg;
    logic [23:0] r_seq;
    logic [15:0] r_delay;
    logic [AW-1:0] r_addr;
    logic [IW-1:0] r_idx;
    logic        r_use_new;
    t_rec        r_newrec;
    t_res        r_dres;
    logic [3:0]  r_dentry;
    logic [23:0] r_did;
    logic        r_pend_v;
    t_res        r_pend_res;
    logic [3:0]  r_pend_entry;
    logic [23:0] r_pend_id;
    logic [4:0]  r_cnt;
    logic        r_out_v;
    t_res        r_out_res;
    logic [3:0]  r_out_entry;
    logic [23:0] r_out_id;
    logic        r_out_last;

    logic [3:0]  w_slot;
    logic [7:0]  w_msg;
    logic [23:0] w_seq;
    logic [15:0] w_delay;
    logic [AW-1:0] w_slot_idx;
    logic        w_ok_slot;
    logic        w_free_v;
    logic [AW-1:0] w_free;
    logic [23:0] w_nxt;
    logic        w_can_push;
    logic        w_we;
    t_rec        w_rdata;
    t_rec        w_rec_in;
    t_rec        w_rec_out;
    logic        w_keep;
    logic        w_hit;
    t_res        w_res;
    logic        w_rep;
    logic        w_stall;
    logic [AW-1:0] w_idx;

    assign w_slot = i_s_axis_tdata[3:0];
    assign w_msg = i_s_axis_tdata[11:4];
    assign w_seq = i_s_axis_tdata[35:12];
    assign w_delay = i_s_axis_tdata[51:36];
    assign w_slot_idx = AW'(w_slot);
    assign w_ok_slot = (32'(w_slot) < SLOTS) && r_valid[w_slot_idx];
    assign w_nxt = (r_next_id >= ID_WRAP) ? 24'd1 : r_next_id + 24'd1;
    assign w_can_push = !r_out_v || i_m_axis_tready;
    assign w_idx = r_idx[AW-1:0];
    assign w_rec_in = r_use_new ? r_newrec : w_rdata;
    assign w_rep = w_hit && (r_cnt < 5'(MAX_OUT));
    assign w_stall = w_rep && r_pend_v && !w_can_push;
    assign w_we = ((r_state == S_EXEC) && w_can_push) || ((r_state == S_TK_C) && !w_stall);

    always_comb begin
        w_free_v = 1'b0;
        w_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_v = 1'b1;
                w_free = AW'(i);
            end
        end
    end

    pfcp_tt_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_rec_out),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    pfcp_tt_update u_update (
        .i_op       (r_op),
        .i_rec      (w_rec_in),
        .i_cfg      (r_cfg),
        .i_msg_type (r_msg),
        .i_delay    (r_delay),
        .o_rec      (w_rec_out),
        .o_keep     (w_keep),
        .o_hit      (w_hit),
        .o_res      (w_res)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tlast = r_out_last;
    assign o_m_axis_tdata = {5'd0, r_out_res.rem, r_out_res.gave, r_out_res.sstep,
                             r_out_res.send, r_out_id, r_out_entry, r_out_res.st};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_cfg.rretries <= 4'd3;
            r_cfg.rticks <= 16'd3000;
            r_cfg.hretries <= 4'd4;
            r_cfg.hticks <= 16'd3000;
            r_next_id <= 24'd1;
            r_valid <= '0;
            r_pend_v <= 1'b0;
            r_out_v <= 1'b0;
            r_use_new <= 1'b0;
        end else begin
            if (r_out_v && i_m_axis_tready) r_out_v <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RRETRIES: r_cfg.rretries <= i_cfg_data[3:0];
                    CFG_RTICKS:   r_cfg.rticks <= i_cfg_data[15:0];
                    CFG_HRETRIES: r_cfg.hretries <= i_cfg_data[3:0];
                    CFG_HTICKS:   r_cfg.hticks <= i_cfg_data[15:0];
                    CFG_FIRST_ID: r_next_id <= {1'b0, i_cfg_data};
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op <= i_s_axis_tuser;
                        r_msg <= w_msg;
                        r_seq <= w_seq;
                        r_delay <= w_delay;
                        r_idx <= '0;
                        r_cnt <= '0;
                        r_use_new <= 1'b0;
                        r_dres <= '0;
                        r_dentry <= w_slot;
                        r_did <= '0;
                        case (i_s_axis_tuser) inside
                            REQ_CREATE: begin
                                if (w_free_v) begin
                                    r_next_id <= w_nxt;
                                    r_addr <= w_free;
                                    r_use_new <= 1'b1;
                                    r_newrec <= '{remote: 1'b0, id: w_nxt, step: 2'd0,
                                                  msg: '0, mask: 3'd0,
                                                  rleft: r_cfg.rretries,
                                                  hleft: r_cfg.hretries,
                                                  rtimer: 16'd0, htimer: 16'd0,
                                                  ctimer: 16'd0};
                                    r_state <= S_EXEC;
                                end else begin
                                    r_dres.st <= ST_FULL;
                                    r_dentry <= 4'd0;
                                    r_state <= S_DIRECT;
                                end
                            end
                            REQ_TRANSMIT, REQ_COMMIT, REQ_DCOMMIT, REQ_DELETE: begin
                                if (w_ok_slot) begin
                                    r_addr <= w_slot_idx;
                                    r_ret <= S_EXEC;
                                    r_state <= S_WAIT;
                                end else begin
                                    r_dres.st <= ST_ERR;
                                    r_state <= S_DIRECT;
                                end
                            end
                            REQ_RECEIVE: begin
                                if (kind_of(w_msg) == KIND_NONE) begin
                                    r_dres.st <= ST_ERR;
                                    r_dentry <= 4'd0;
                                    r_did <= w_seq;
                                    r_state <= S_DIRECT;
                                end else begin
                                    r_state <= S_RS_A;
                                end
                            end
                            REQ_TICK: begin
                                r_state <= S_TK_A;
                            end
                            default: begin
                                r_dres.st <= ST_ERR;
                                r_dentry <= 4'd0;
                                r_state <= S_DIRECT;
                            end
                        endcase
                    end
                end
                S_WAIT: begin
                    r_state <= r_ret;
                end
                S_DIRECT: begin
                    if (w_can_push) begin
                        r_out_v <= 1'b1;
                        r_out_res <= r_dres;
                        r_out_entry <= r_dentry;
                        r_out_id <= r_did;
                        r_out_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_EXEC: begin
                    if (w_can_push) begin
                        r_valid[r_addr] <= w_keep;
                        r_out_v <= 1'b1;
                        r_out_res <= w_res;
                        r_out_entry <= 4'(r_addr);
                        r_out_id <= w_rec_out.id;
                        r_out_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_RS_A: begin
                    if (r_idx == IW'(SLOTS)) begin
                        if (w_free_v) begin
                            r_addr <= w_free;
                            r_use_new <= 1'b1;
                            r_newrec <= '{remote: 1'b1, id: r_seq, step: 2'd0,
                                          msg: '0, mask: 3'd0,
                                          rleft: r_cfg.rretries,
                                          hleft: r_cfg.hretries,
                                          rtimer: 16'd0, htimer: 16'd0, ctimer: 16'd0};
                            r_state <= S_EXEC;
                        end else begin
                            r_dres.st <= ST_FULL;
                            r_dentry <= 4'd0;
                            r_did <= r_seq;
                            r_state <= S_DIRECT;
                        end
                    end else if (r_valid[w_idx]) begin
                        r_addr <= w_idx;
                        r_ret <= S_RS_C;
                        r_state <= S_WAIT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_RS_C: begin
                    if (w_rdata.remote == (kind_of(r_msg) == KIND_REQ) &&
                        w_rdata.id == r_seq) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                        r_state <= S_RS_A;
                    end
                end
                S_TK_A: begin
                    if (r_idx == IW'(SLOTS)) begin
                        r_state <= S_TK_END;
                    end else if (r_valid[w_idx]) begin
                        r_addr <= w_idx;
                        r_ret <= S_TK_C;
                        r_state <= S_WAIT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_TK_C: begin
                    if (!w_stall) begin
                        r_valid[r_addr] <= w_keep;
                        if (w_rep) begin
                            if (r_pend_v) begin
                                r_out_v <= 1'b1;
                                r_out_res <= r_pend_res;
                                r_out_entry <= r_pend_entry;
                                r_out_id <= r_pend_id;
                                r_out_last <= 1'b0;
                            end
                            r_pend_v <= 1'b1;
                            r_pend_res <= w_res;
                            r_pend_entry <= 4'(r_addr);
                            r_pend_id <= w_rec_out.id;
                            r_cnt <= r_cnt + 5'd1;
                        end
                        r_idx <= r_idx + IW'(1);
                        r_state <= S_TK_A;
                    end
                end
                S_TK_END: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (w_can_push) begin
                        r_out_v <= 1'b1;
                        r_out_res <= r_pend_res;
                        r_out_entry <= r_pend_entry;
                        r_out_id <= r_pend_id;
                        r_out_last <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
